// ----- hdl/dhtfe_pkg.sv -----
// Shared codes, field widths and types for the ring successor engine
`default_nettype none
package dhtfe_pkg;

   localparam int FUNC_W   = 2;
   localparam int NODE_W   = 8;
   localparam int KEY_W    = 8;
   localparam int FIDX_W   = 3;
   localparam int RESULT_W = 8;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_JOIN   = 2'd0,
      FUNC_LEAVE  = 2'd1,
      FUNC_LOCATE = 2'd2,
      FUNC_FINGER = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_DUP    = 3'd1,
      STATUS_FULL   = 3'd2,
      STATUS_ABSENT = 3'd3,
      STATUS_EMPTY  = 3'd4
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/dhtfe_if.sv -----
// Request and response channel interfaces
`default_nettype none
interface dhtfe_req_if;
   import dhtfe_pkg::*;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [NODE_W-1:0]   node_id;
   logic [KEY_W-1:0]    key;
   logic [FIDX_W-1:0]   finger_index;

   modport source (output valid, func, node_id, key, finger_index, input ready);
   modport sink   (input valid, func, node_id, key, finger_index, output ready);
endinterface

interface dhtfe_rsp_if;
   import dhtfe_pkg::*;
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] result_node;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  member_total;

   modport source (output valid, result_node, status, member_total, input ready);
   modport sink   (input valid, result_node, status, member_total, output ready);
endinterface
`default_nettype wire

// ----- hdl/dht_ring_successor_finger_engine_unit.sv -----
// Top level of the identifier ring membership and successor engine
//
//   channel  dir  handshake      beat
//   req_if   in   valid/ready    func, node_id, key, finger_index
//   rsp_if   out  valid/ready    result_node, status, member_total
//
// Join, leave and refused requests finish in the check state, once the map word of the queue head is read.
// Locate and finger then scan the map one 16-bit word at a time (narrower words
// for tiny rings), at most one full wrap plus the start word again.
// After reset a clearing pass zeroes all 2^(ID_BITS-4) map words (two for ID_BITS
// below 5); req_if is not ready during it.
// A result is held until taken; a two-beat queue keeps req_if open meanwhile.
`default_nettype none
module dht_ring_successor_finger_engine_unit #(
   parameter int ID_BITS = 8
) (
   input wire logic    clock,
   input wire logic    reset,
   dhtfe_req_if.sink   req_if,
   dhtfe_rsp_if.source rsp_if
);
   import dhtfe_pkg::*;

   localparam int ITEM_W = FUNC_W + 2 * ID_BITS;

   logic              push_valid, push_ready;
   logic [ITEM_W-1:0] push_data, head_data;
   logic              head_valid, head_pop, clearing;

   dhtfe_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .req_if     (req_if),
      .clearing   (clearing),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   dhtfe_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dhtfe_back #(
      .ID_BITS (ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .clearing   (clearing),
      .rsp_if     (rsp_if)
   );
endmodule
`default_nettype wire

// ----- hdl/dhtfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module dhtfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hdl/dhtfe_front.sv -----
// Front end: takes request beats, reduces identifiers and forms the search target
`default_nettype none
module dhtfe_front #(
   parameter int ID_BITS = 8
) (
   dhtfe_req_if.sink                  req_if,
   input  wire logic                  clearing,
   input  wire logic                  push_ready,
   output logic                       push_valid,
   output logic [2+2*ID_BITS-1:0]     push_data
);
   import dhtfe_pkg::*;

   logic [ID_BITS-1:0] node;
   logic [ID_BITS-1:0] key_r;
   logic [ID_BITS-1:0] offset;
   logic [ID_BITS-1:0] target;

   always_comb begin
      node   = ID_BITS'(req_if.node_id);
      key_r  = ID_BITS'(req_if.key);
      // offsets at or beyond the ring width shift out to zero
      offset = ID_BITS'(1) << req_if.finger_index;
      if (func_type'(req_if.func) == FUNC_LOCATE) begin
         target = key_r;
      end else begin
         target = node + offset;
      end
   end

   assign req_if.ready = push_ready && !clearing;
   assign push_valid   = req_if.valid && !clearing;
   assign push_data    = {req_if.func, node, target};
endmodule
`default_nettype wire

// ----- hdl/dhtfe_fifo.sv -----
// Short queue between front and back ends
`default_nettype none
module dhtfe_fifo #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  push_ready,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;
   logic             push;

   assign push_ready = fill_ff != CNT_W'(DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hdl/dhtfe_back.sv -----
// Back end: membership checks, map updates and word-wise successor scan
`default_nettype none
module dhtfe_back #(
   parameter int ID_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire logic [2+2*ID_BITS-1:0] head_data,
   output logic                        head_pop,
   output logic                        clearing,
   dhtfe_rsp_if.source                 rsp_if
);
   import dhtfe_pkg::*;

   localparam int RING     = 1 << ID_BITS;
   localparam int WORD_LOG = (ID_BITS > 4) ? 4 : ID_BITS - 1;
   localparam int WORD_W   = 1 << WORD_LOG;
   localparam int ADDR_W   = ID_BITS - WORD_LOG;
   localparam int DEPTH    = 1 << ADDR_W;
   localparam int CNT_W    = ID_BITS + 1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN
   } state_type;

   state_type            state_ff, state_in;
   func_type             func_ff;
   logic [ID_BITS-1:0]   node_ff, target_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [ADDR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                 first_ff, first_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff;
   logic [RESULT_W-1:0]  result_ff;
   status_type           status_ff;
   logic [TOTAL_W-1:0]   total_ff;

   func_type             head_func;
   logic [ID_BITS-1:0]   head_node, head_target;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [WORD_W-1:0]    wr_data, rd_data;
   logic [WORD_W-1:0]    node_onehot, scan_mask, masked;
   logic [WORD_LOG-1:0]  low_idx;
   logic                 node_bit, found, ring_full, fin;
   status_type           status_in;
   logic [ID_BITS-1:0]   result_in;

   dhtfe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_func   = func_type'(head_data[2+2*ID_BITS-1 -: 2]);
   assign head_node   = head_data[2*ID_BITS-1 -: ID_BITS];
   assign head_target = head_data[ID_BITS-1:0];
   assign head_pop    = (state_ff == S_IDLE) && head_valid && !rsp_valid_ff;
   assign clearing    = state_ff == S_CLEAR;

   assign node_bit    = rd_data[node_ff[WORD_LOG-1:0]];
   assign node_onehot = WORD_W'(1) << node_ff[WORD_LOG-1:0];
   assign ring_full   = count_ff == CNT_W'(RING);
   // first word of a scan ignores positions below the target
   assign scan_mask   = first_ff ? ({WORD_W{1'b1}} << target_ff[WORD_LOG-1:0])
                                 : {WORD_W{1'b1}};
   assign masked      = rd_data & scan_mask;
   assign found       = |masked;

   always_comb begin
      low_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            low_idx = WORD_LOG'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      scan_addr_in = scan_addr_ff;
      fin          = 1'b0;
      status_in    = STATUS_OK;
      result_in    = '0;
      wr_en        = 1'b0;
      wr_addr      = node_ff[ID_BITS-1:WORD_LOG];
      wr_data      = rd_data;
      rd_addr      = head_node[ID_BITS-1:WORD_LOG];
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_pop) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (func_ff)
               FUNC_JOIN: begin
                  fin = 1'b1;
                  if (ring_full) begin
                     status_in = STATUS_FULL;
                  end else if (node_bit) begin
                     status_in = STATUS_DUP;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = rd_data | node_onehot;
                     count_in = count_ff + 1'b1;
                  end
               end
               FUNC_LEAVE: begin
                  fin = 1'b1;
                  if (!node_bit) begin
                     status_in = STATUS_ABSENT;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = rd_data & ~node_onehot;
                     count_in = count_ff - 1'b1;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     fin       = 1'b1;
                     status_in = STATUS_EMPTY;
                  end else if (!node_bit) begin
                     fin       = 1'b1;
                     status_in = STATUS_ABSENT;
                  end else begin
                     state_in     = S_SCAN;
                     first_in     = 1'b1;
                     scan_addr_in = target_ff[ID_BITS-1:WORD_LOG];
                     rd_addr      = target_ff[ID_BITS-1:WORD_LOG];
                  end
               end
            endcase
            if (fin) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (found) begin
               fin       = 1'b1;
               result_in = {scan_addr_ff, low_idx};
               state_in  = S_IDLE;
            end else begin
               first_in     = 1'b0;
               scan_addr_in = scan_addr_ff + 1'b1;
               rd_addr      = scan_addr_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         first_ff <= first_in;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (fin) begin
            rsp_valid_ff <= 1'b1;
            result_ff    <= RESULT_W'(result_in);
            status_ff    <= status_in;
            total_ff     <= TOTAL_W'(count_in);
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      if (head_pop) begin
         func_ff   <= head_func;
         node_ff   <= head_node;
         target_ff <= head_target;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_node  = result_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.member_total = total_ff;
endmodule
`default_nettype wire
